/* rtl/spath_pkg.sv */
// Shared types and constants for the shortest path search block.
// No dependencies; imported by every module of the block.
package spath_pkg;

    // Parameter defaults
    localparam int NODES_DEF      = 64;
    localparam int COST_BITS_DEF  = 16;
    localparam int TOTAL_BITS_DEF = 22;

    // Fixed word field widths
    localparam int NODE_W  = 6;
    localparam int LEG_W   = 15;
    localparam int TOTAL_W = 22;
    localparam int LEG_MAX = 32767;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic CFG_SOURCE = 1'b0;
    localparam logic CFG_TARGET = 1'b1;

    // Input word modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RUN  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEL,
        ST_RELAX,
        ST_WALK,
        ST_WALK_WAIT,
        ST_E_RD,
        ST_E_NODE,
        ST_E_OUT,
        ST_RES
    } t_state;

    typedef struct packed {
        logic [NODE_W-1:0]  node;
        logic [LEG_W-1:0]   leg;
        logic [TOTAL_W-1:0] total;
        logic               found;
        logic               neg;
        logic               last;
    } t_res;

endpackage

/* rtl/spath_cfg.sv */
// APB register file: source and target node registers.
// Depends on spath_pkg.
module spath_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [spath_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [spath_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [spath_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output logic [spath_pkg::NODE_W-1:0]      o_src,
    output logic [spath_pkg::NODE_W-1:0]      o_tgt
);
    import spath_pkg::*;

    logic [NODE_W-1:0] r_src, r_tgt;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= '0;
            r_tgt <= '0;
        end else if (wr_en) begin
            case (paddr[2])
                CFG_SOURCE: r_src <= pwdata[NODE_W-1:0];
                CFG_TARGET: r_tgt <= pwdata[NODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (paddr[2])
            CFG_SOURCE: prdata = APB_DATA_W'(r_src);
            CFG_TARGET: prdata = APB_DATA_W'(r_tgt);
            default:    prdata = '0;
        endcase
    end

    assign o_src = r_src;
    assign o_tgt = r_tgt;

endmodule

/* rtl/spath_engine.sv */
// Search engine: weight, best-cost and path memories plus the sequencer
// that loads edges, scans, relaxes, walks back and emits the path, or a single not-found or negative-edge word.
// Depends on spath_pkg.
module spath_engine #(
    parameter int NODES      = spath_pkg::NODES_DEF,
    parameter int COST_BITS  = spath_pkg::COST_BITS_DEF,
    parameter int TOTAL_BITS = spath_pkg::TOTAL_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_mode,
    input  logic [spath_pkg::NODE_W-1:0] i_from_node,
    input  logic [spath_pkg::NODE_W-1:0] i_to_node,
    input  logic signed [COST_BITS-1:0] i_edge_cost,
    input  logic                        i_edge_present,
    input  logic [spath_pkg::NODE_W-1:0] i_src,
    input  logic [spath_pkg::NODE_W-1:0] i_tgt,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output spath_pkg::t_res             o_res
);
    import spath_pkg::*;

    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int AW = $clog2(NODES * NODES);
    localparam int SW = ((TOTAL_BITS > COST_BITS) ? TOTAL_BITS : COST_BITS) + 1;
    localparam int BW = TOTAL_BITS + NW;

    // Memories
    logic [COST_BITS:0] wmem [NODES*NODES];
    logic [BW-1:0]      bmem [NODES];
    logic [NW-1:0]      pmem [NODES];

    logic               mw_we;
    logic [AW-1:0]      mw_waddr, mw_raddr;
    logic [COST_BITS:0] mw_wdata;
    logic               mb_we;
    logic [NW-1:0]      mb_waddr, mb_raddr;
    logic [BW-1:0]      mb_wdata;
    logic               mp_we;
    logic [NW-1:0]      mp_waddr, mp_raddr;
    logic [NW-1:0]      mp_wdata;
    logic [COST_BITS:0] r_wq;
    logic [BW-1:0]      r_bq;
    logic [NW-1:0]      r_pq;

    always_ff @(posedge i_clk) begin
        if (mw_we) wmem[mw_waddr] <= mw_wdata;
        r_wq <= wmem[mw_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (mb_we) bmem[mb_waddr] <= mb_wdata;
        r_bq <= bmem[mb_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (mp_we) pmem[mp_waddr] <= mp_wdata;
        r_pq <= pmem[mp_raddr];
    end

    // Sequencer state
    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic [NW-1:0]     r_s, n_s, r_t, n_t;
    logic [NODES-1:0]  r_reached, n_reached, r_settled, n_settled;
    logic [NW:0]       r_v, n_v;
    logic [NW-1:0]     r_sv, n_sv;
    logic              r_svv, n_svv;
    logic              r_any, n_any;
    logic [NW-1:0]     r_u, n_u;
    logic [TOTAL_BITS-1:0] r_ubest, n_ubest;
    logic [NW:0]       r_cnt, n_cnt, r_k, n_k;
    logic [NW-1:0]     r_n, n_n, r_prev, n_prev, r_node, n_node;
    logic              r_neg, n_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_reached <= '0;
            r_settled <= '0;
            r_svv     <= 1'b0;
            r_any     <= 1'b0;
            r_neg     <= 1'b0;
            r_v       <= '0;
            r_cnt     <= '0;
            r_k       <= '0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_reached <= n_reached;
            r_settled <= n_settled;
            r_svv     <= n_svv;
            r_any     <= n_any;
            r_neg     <= n_neg;
            r_v       <= n_v;
            r_cnt     <= n_cnt;
            r_k       <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s     <= n_s;
        r_t     <= n_t;
        r_sv    <= n_sv;
        r_u     <= n_u;
        r_ubest <= n_ubest;
        r_n     <= n_n;
        r_prev  <= n_prev;
        r_node  <= n_node;
    end

    // Datapath helpers
    logic [NW-1:0]         ld_from, ld_to, in_s;
    logic                  ld_ok, run_ok;
    logic                  w_on;
    logic [COST_BITS-1:0]  w_cost;
    logic [SW-1:0]         w_sum;
    logic [TOTAL_BITS-1:0] w_nb, b_best;
    logic                  issue;
    logic [NW:0]           cnt_inc, k_inc, e_idx;
    logic [LEG_W-1:0]      leg_sat;

    assign ld_from = NW'(i_from_node);
    assign ld_to   = NW'(i_to_node);
    assign in_s    = NW'(i_src);
    assign ld_ok   = (32'(i_from_node) < 32'(NODES)) && (32'(i_to_node) < 32'(NODES));
    assign run_ok  = (32'(i_src) < 32'(NODES)) && (32'(i_tgt) < 32'(NODES));
    assign w_on    = r_wq[COST_BITS];
    assign w_cost  = r_wq[COST_BITS-1:0];
    assign b_best  = r_bq[BW-1:NW];
    // saturating new total
    assign w_sum   = SW'(r_ubest) + SW'(w_cost);
    assign w_nb    = (w_sum > SW'({TOTAL_BITS{1'b1}})) ? {TOTAL_BITS{1'b1}}
                                                      : TOTAL_BITS'(w_sum);
    assign issue   = r_v < (NW+1)'(NODES);
    assign cnt_inc = r_cnt + 1'b1;
    assign k_inc   = r_k + 1'b1;
    assign e_idx   = r_cnt - k_inc;
    assign leg_sat = (64'(w_cost) > 64'(LEG_MAX)) ? LEG_W'(LEG_MAX) : LEG_W'(w_cost);

    // Next state and memory control
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_s       = r_s;
        n_t       = r_t;
        n_reached = r_reached;
        n_settled = r_settled;
        n_v       = r_v;
        n_sv      = r_sv;
        n_svv     = r_svv;
        n_any     = r_any;
        n_u       = r_u;
        n_ubest   = r_ubest;
        n_cnt     = r_cnt;
        n_k       = r_k;
        n_n       = r_n;
        n_prev    = r_prev;
        n_node    = r_node;
        n_neg     = r_neg;

        mw_we    = 1'b0;
        mw_waddr = AW'(ld_from) * AW'(NODES) + AW'(ld_to);
        mw_wdata = {i_edge_present, i_edge_present ? i_edge_cost : '0};
        mw_raddr = AW'(r_prev) * AW'(NODES) + AW'(r_node);
        mb_we    = 1'b0;
        mb_waddr = r_sv;
        mb_wdata = {w_nb, r_u};
        mb_raddr = r_v[NW-1:0];
        mp_we    = 1'b0;
        mp_waddr = r_cnt[NW-1:0];
        mp_wdata = r_n;
        mp_raddr = e_idx[NW-1:0];

        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.last  = 1'b1;

        case (r_state)
            // wipe the weight store after reset
            ST_CLEAR: begin
                mw_we    = 1'b1;
                mw_waddr = r_clr;
                mw_wdata = '0;
                n_clr    = r_clr + 1'b1;
                if (r_clr == AW'(NODES * NODES - 1)) n_state = ST_IDLE;
            end

            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_mode == MODE_LOAD) begin
                        mw_we = ld_ok;
                    end else begin
                        n_settled = '0;
                        n_reached = '0;
                        n_neg     = 1'b0;
                        if (run_ok) begin
                            n_s             = in_s;
                            n_t             = NW'(i_tgt);
                            n_reached[in_s] = 1'b1;
                            mb_we           = 1'b1;
                            mb_waddr        = in_s;
                            mb_wdata        = {{TOTAL_BITS{1'b0}}, in_s};
                            n_v             = '0;
                            n_svv           = 1'b0;
                            n_any           = 1'b0;
                            n_state         = ST_SEL;
                        end else begin
                            n_state = ST_RES;
                        end
                    end
                end
            end

            // scan for the cheapest reached, unsettled node
            ST_SEL: begin
                n_svv = issue;
                n_sv  = r_v[NW-1:0];
                if (issue) n_v = r_v + 1'b1;
                if (r_svv && r_reached[r_sv] && !r_settled[r_sv]
                        && (!r_any || b_best < r_ubest)) begin
                    n_any   = 1'b1;
                    n_u     = r_sv;
                    n_ubest = b_best;
                end
                if (!issue && !r_svv) begin
                    if (!r_any) begin
                        n_state = ST_RES;
                    end else begin
                        n_settled[r_u] = 1'b1;
                        n_v            = '0;
                        n_state        = ST_RELAX;
                    end
                end
            end

            // relax the outgoing edges of the settled node
            ST_RELAX: begin
                mw_raddr = AW'(r_u) * AW'(NODES) + AW'(r_v[NW-1:0]);
                n_svv    = issue;
                n_sv     = r_v[NW-1:0];
                if (issue) n_v = r_v + 1'b1;
                if (r_svv && w_on) begin
                    if (w_cost[COST_BITS-1]) begin
                        n_neg   = 1'b1;
                        n_svv   = 1'b0;
                        n_state = ST_RES;
                    end else if (!r_reached[r_sv] || w_nb < b_best) begin
                        mb_we           = 1'b1;
                        n_reached[r_sv] = 1'b1;
                    end
                end
                if (!issue && !r_svv) begin
                    if (r_u == r_t) begin
                        n_n     = r_t;
                        n_cnt   = '0;
                        n_state = ST_WALK;
                    end else begin
                        n_v     = '0;
                        n_any   = 1'b0;
                        n_state = ST_SEL;
                    end
                end
            end

            // follow predecessors back to the source
            ST_WALK: begin
                mp_we = 1'b1;
                n_cnt = cnt_inc;
                if (r_n == r_s || cnt_inc == (NW+1)'(NODES)) begin
                    n_k     = '0;
                    n_state = ST_E_RD;
                end else begin
                    mb_raddr = r_n;
                    n_state  = ST_WALK_WAIT;
                end
            end

            ST_WALK_WAIT: begin
                n_n     = r_bq[NW-1:0];
                n_state = ST_WALK;
            end

            // emit path words, source first
            ST_E_RD: begin
                n_state = ST_E_NODE;
            end

            ST_E_NODE: begin
                n_node   = r_pq;
                mw_raddr = AW'(r_prev) * AW'(NODES) + AW'(r_pq);
                n_state  = ST_E_OUT;
            end

            ST_E_OUT: begin
                o_res_valid = 1'b1;
                o_res.node  = NODE_W'(r_node);
                o_res.leg   = (r_k == '0) ? '0 : leg_sat;
                o_res.total = TOTAL_W'(r_ubest);
                o_res.found = 1'b1;
                o_res.last  = (k_inc == r_cnt);
                if (i_res_ready) begin
                    n_prev  = r_node;
                    n_k     = k_inc;
                    n_state = (k_inc == r_cnt) ? ST_IDLE : ST_E_RD;
                end
            end

            // single not-found or negative-edge word
            ST_RES: begin
                o_res_valid = 1'b1;
                o_res.neg   = r_neg;
                if (i_res_ready) n_state = ST_IDLE;
            end

            default: n_state = ST_IDLE;
        endcase
    end

endmodule

/* rtl/shortest_path_search.sv */
// Shortest path search: edge loads are accepted back to back while idle.
// A run scans and relaxes once per settled node (over the best-cost and
// weight memories), walks back over the path nodes and emits one word per
// path node. After reset the weight store, NODES*NODES entries (4096 by
// default), is cleared before the first word is taken.
module shortest_path_search #(
    parameter int NODES      = spath_pkg::NODES_DEF,
    parameter int COST_BITS  = spath_pkg::COST_BITS_DEF,
    parameter int TOTAL_BITS = spath_pkg::TOTAL_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_mode,
    input  logic [spath_pkg::NODE_W-1:0]     i_from_node,
    input  logic [spath_pkg::NODE_W-1:0]     i_to_node,
    input  logic signed [COST_BITS-1:0]      i_edge_cost,
    input  logic                             i_edge_present,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [spath_pkg::NODE_W-1:0]     o_path_node,
    output logic [spath_pkg::LEG_W-1:0]      o_leg_cost,
    output logic [spath_pkg::TOTAL_W-1:0]    o_total_cost,
    output logic                             o_found,
    output logic                             o_negative_error,
    output logic                             o_last,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [spath_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [spath_pkg::APB_DATA_W-1:0] pwdata,
    output logic [spath_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import spath_pkg::*;

    logic [NODE_W-1:0] cfg_src, cfg_tgt;
    logic              res_valid, res_ready;
    t_res              res, r_out;
    logic              r_out_valid;

    spath_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_src   (cfg_src),
        .o_tgt   (cfg_tgt)
    );

    spath_engine #(
        .NODES      (NODES),
        .COST_BITS  (COST_BITS),
        .TOTAL_BITS (TOTAL_BITS)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_from_node    (i_from_node),
        .i_to_node      (i_to_node),
        .i_edge_cost    (i_edge_cost),
        .i_edge_present (i_edge_present),
        .i_src          (cfg_src),
        .i_tgt          (cfg_tgt),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res)
    );

    // Output word register
    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) r_out <= res;
    end

    assign o_valid          = r_out_valid;
    assign o_path_node      = r_out.node;
    assign o_leg_cost       = r_out.leg;
    assign o_total_cost     = r_out.total;
    assign o_found          = r_out.found;
    assign o_negative_error = r_out.neg;
    assign o_last           = r_out.last;

endmodule

/* verif/tb.sv */
// Testbench for shortest_path_search: loads edges, runs searches, and checks every
// path word against a local route planner. Depends on rtl/spath_pkg.sv and
// rtl/shortest_path_search.sv.
module tb;
    import spath_pkg::*;

    localparam int N        = 64;
    localparam int TOT_MAX  = (1 << TOTAL_W) - 1;
    localparam int IDLE_MAX = 60000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_mode = MODE_LOAD;
    logic [NODE_W-1:0] i_from_node = '0;
    logic [NODE_W-1:0] i_to_node = '0;
    logic signed [15:0] i_edge_cost = '0;
    logic i_edge_present = 1'b0;
    logic i_ready = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic o_ready, o_valid, o_found, o_negative_error, o_last, pready;
    logic [NODE_W-1:0] o_path_node;
    logic [LEG_W-1:0] o_leg_cost;
    logic [TOTAL_W-1:0] o_total_cost;
    logic [APB_DATA_W-1:0] prdata;

    shortest_path_search uut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Local copy of the graph and registers
    bit          link_on [N*N];
    logic [15:0] link_km [N*N];
    int          src_reg = 0;
    int          dst_reg = 0;

    t_res route_words_due[$];
    int   faults = 0;
    int   words_sent = 0;
    bit   tx_calm = 1'b0;
    int   subset[6];

    // Dijkstra over the local graph; queues the words one search should give
    function automatic void plan_route();
        bit  reach[N];
        bit  done[N];
        int  best[N];
        int  pred[N];
        int  path[N];
        int  u, v, idx, nb, cnt, n, k;
        bit  any;
        t_res r;
        for (v = 0; v < N; v++) begin
            reach[v] = 0;
            done[v] = 0;
        end
        reach[src_reg] = 1;
        best[src_reg] = 0;
        pred[src_reg] = src_reg;
        while (1) begin
            any = 0;
            u = 0;
            for (v = 0; v < N; v++)
                if (reach[v] && !done[v] && (!any || best[v] < best[u])) begin
                    u = v;
                    any = 1;
                end
            if (!any) break;
            done[u] = 1;
            for (v = 0; v < N; v++) begin
                idx = u * N + v;
                if (!link_on[idx]) continue;
                if (link_km[idx][15]) begin
                    r = '0;
                    r.neg = 1'b1;
                    r.last = 1'b1;
                    route_words_due = {route_words_due, r};
                    return;
                end
                nb = best[u] + int'(link_km[idx]);
                if (nb > TOT_MAX) nb = TOT_MAX;
                if (!reach[v] || nb < best[v]) begin
                    reach[v] = 1;
                    best[v] = nb;
                    pred[v] = u;
                end
            end
            if (u == dst_reg) break;
        end
        if (!reach[dst_reg]) begin
            r = '0;
            r.last = 1'b1;
            route_words_due = {route_words_due, r};
            return;
        end
        cnt = 1;
        n = dst_reg;
        path[0] = n;
        while (n != src_reg && cnt < N) begin
            n = pred[n];
            path[cnt] = n;
            cnt++;
        end
        for (k = 0; k < cnt; k++) begin
            r = '0;
            r.node = NODE_W'(path[cnt-1-k]);
            if (k > 0) begin
                idx = path[cnt-k] * N + path[cnt-1-k];
                r.leg = (link_km[idx] > LEG_MAX) ? LEG_W'(LEG_MAX)
                                                 : link_km[idx][LEG_W-1:0];
            end
            r.total = TOTAL_W'(best[dst_reg]);
            r.found = 1'b1;
            r.last = (k + 1 == cnt);
            route_words_due = {route_words_due, r};
        end
    endfunction

    // Send one word; gap first, then hold valid until it is taken
    task automatic send_word(input logic mode, input int fr, input int to,
                             input int km, input bit present);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        gap = tx_calm ? 0 : (roll < 60) ? 0 : (roll < 92) ? $urandom_range(1, 3)
                                                        : $urandom_range(10, 40);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_from_node <= fr[NODE_W-1:0];
        i_to_node <= to[NODE_W-1:0];
        i_edge_cost <= km[15:0];
        i_edge_present <= present;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
        if (mode == MODE_RUN) begin
            plan_route();
        end else begin
            link_on[fr*N+to] = present;
            link_km[fr*N+to] = present ? km[15:0] : 16'd0;
        end
    endtask

    task automatic load_edge(input int fr, input int to, input int km, input bit present);
        send_word(MODE_LOAD, fr, to, km, present);
    endtask

    task automatic run_search();
        send_word(MODE_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 65535), $urandom_range(0, 1));
    endtask

    // Hold off until every queued path word has come back, then let loads settle
    task automatic drain();
        i_valid <= 1'b0;
        while (route_words_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic which, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {which, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (which == CFG_SOURCE) src_reg = value & 63;
        else dst_reg = value & 63;
    endtask

    task automatic set_route(input int s, input int t);
        write_reg(CFG_SOURCE, s);
        write_reg(CFG_TARGET, t);
    endtask

    // Corner cases: source on target, unreachable, ties, negative edges, removal
    task automatic test_directed();
        set_route(0, 0);
        run_search();
        drain();
        write_reg(CFG_TARGET, 63);
        run_search();
        load_edge(0, 5, 100, 1);
        load_edge(5, 63, 32767, 1);
        load_edge(0, 63, 32767, 1);
        load_edge(0, 7, 100, 1);
        load_edge(7, 63, 32767, 1);
        run_search();
        load_edge(0, 63, -1, 0);
        run_search();
        load_edge(63, 0, -32768, 1);
        run_search();
        load_edge(63, 0, 0, 0);
        load_edge(63, 63, -1, 0);
        load_edge(5, 7, 0, 1);
        run_search();
        drain();
        set_route(63, 0);
        load_edge(63, 0, 1, 1);
        run_search();
        load_edge(7, 0, -5, 1);
        load_edge(63, 7, 0, 1);
        run_search();
        load_edge(7, 0, 0, 0);
        run_search();
        drain();
    endtask

    // Random phases: small node clusters, mostly sane edges, some noise
    task automatic test_random();
        int items, k, roll, a, b;
        while (words_sent < 450) begin
            drain();
            tx_calm = ($urandom_range(0, 4) == 0);
            for (k = 0; k < 6; k++) subset[k] = $urandom_range(0, 63);
            roll = $urandom_range(0, 9);
            a = (roll == 0) ? 0 : (roll == 1) ? 63 : subset[$urandom_range(0, 5)];
            roll = $urandom_range(0, 9);
            b = (roll == 0) ? 63 : (roll == 1) ? 0 : subset[$urandom_range(0, 5)];
            set_route(a, b);
            items = $urandom_range(20, 40);
            for (k = 0; k < items; k++) begin
                roll = $urandom_range(0, 99);
                a = subset[$urandom_range(0, 5)];
                b = subset[$urandom_range(0, 5)];
                if (roll < 15) run_search();
                else if (roll < 63) load_edge(a, b, $urandom_range(0, 2000), 1);
                else if (roll < 73) load_edge(a, b, $urandom_range(30000, 32767), 1);
                else if (roll < 76) load_edge(a, b, -$urandom_range(1, 32768), 1);
                else if (roll < 90) load_edge(a, b, $urandom_range(0, 65535) - 32768, 0);
                else load_edge($urandom_range(0, 63), $urandom_range(0, 63),
                               $urandom_range(0, 65535) - 32768, $urandom_range(0, 1));
            end
        end
        drain();
    endtask

    // Path word checker and receiver stalls
    t_res got, want;
    int   rx_stall = 0;
    int   rx_cycle = 0;
    bit   rx_free = 1'b0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_path_node, o_leg_cost, o_total_cost, o_found, o_negative_error, o_last};
            if (route_words_due.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected word: node %0d leg %0d total %0d f%0b n%0b l%0b",
                             got.node, got.leg, got.total, got.found, got.neg, got.last);
            end else begin
                want = route_words_due.pop_front();
                if (got !== want) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("mismatch: exp node %0d leg %0d total %0d f%0b n%0b l%0b",
                                 want.node, want.leg, want.total, want.found, want.neg,
                                 want.last);
                        $display("          got node %0d leg %0d total %0d f%0b n%0b l%0b",
                                 got.node, got.leg, got.total, got.found, got.neg,
                                 got.last);
                    end
                end
            end
        end
        rx_cycle++;
        if (rx_cycle % 256 == 0) rx_free = ($urandom_range(0, 3) == 0);
        if (rx_free) begin
            i_ready <= 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_ready <= 1'b0;
        end else begin
            case ($urandom_range(0, 19))
                0: rx_stall = $urandom_range(20, 60);
                1, 2, 3, 4: rx_stall = $urandom_range(1, 3);
                default: rx_stall = 0;
            endcase
            i_ready <= (rx_stall == 0);
        end
    end

    // Watchdog: cycles with no traffic on any port
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        repeat (40) @(posedge i_clk);
        if (faults == 0 && route_words_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
